// File: rtl/core/bfbp_pkg.sv
// Shared types and constants of the best-fit buffer pool.
package bfbp_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned HANDLE_W = 16;
  localparam int unsigned SIZE_W   = 32;
  localparam int unsigned FLAGS_W  = 8;
  localparam int unsigned USAGE_W  = 32;
  localparam int unsigned FACTOR_W = 5;
  localparam int unsigned PROD_W   = SIZE_W + FACTOR_W;
  localparam int unsigned DATA_W   = HANDLE_W + SIZE_W + FLAGS_W + USAGE_W;

  localparam logic [FACTOR_W-1:0] FACTOR_RESET = FACTOR_W'(2);

  typedef enum logic [REQ_W-1:0] {
    REQ_ALLOC  = 2'd0,
    REQ_RETURN = 2'd1,
    REQ_FLUSH  = 2'd2,
    REQ_NONE   = 2'd3
  } req_type_e;

  typedef enum logic [STAT_W-1:0] {
    STAT_REUSED  = 3'd0,
    STAT_MISS    = 3'd1,
    STAT_STORED  = 3'd2,
    STAT_FULL    = 3'd3,
    STAT_DESTROY = 3'd4,
    STAT_EMPTY   = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_REMOVE,
    ST_FLUSH,
    ST_PEND
  } state_e;

  typedef struct packed {
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [FLAGS_W-1:0]  flags;
    logic [USAGE_W-1:0]  usage;
  } entry_t;

  // Per-cell control from the sequencer
  typedef struct packed {
    logic load;
    logic shift;
    logic wrap_here;
  } cell_ctrl_t;

endpackage

// File: rtl/core/best_fit_buffer_pool.sv
// Top level of the best-fit buffer pool: ring of entry cells, sequencer and result register.
//
//  Channel   Dir  Handshake                      Payload
//  s_axis    in   s_axis_tvalid_i/tready_o       tuser=req_type, tdata=handle,size,flags,usage
//  m_axis    out  m_axis_tvalid_o/tready_i       tuser=status, tlast=last, tdata=entry fields
//  cfg       in   cfg_we_i (no wait)             cfg_wdata_i=size_factor
//
// Steps: a return or an empty flush passes through a pending state; type 3 gives no result.
// An allocate scans the stored entries, decides, and after a hit closes up the ring. A flush
// sends out every stored entry. The ring of cells moves one entry per cycle past the
// comparator at its head, except while a held result stalls a flush.
// Reset: clears the entry count, the sequencer and the result valid flag and sets
// size_factor to 2; the cells keep whatever they hold until written.
// Stalls: the input is taken only in the idle state; a held result stalls the flush, the
// decide step and a pending single result, while a close-up pass runs on behind it.
module best_fit_buffer_pool #(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  // slave side
  input  logic                                    s_axis_tvalid_i,
  output logic                                    s_axis_tready_o,
  // [1:0] req_type
  input  logic [bfbp_pkg::REQ_W-1:0]              s_axis_tuser_i,
  // [15:0] handle, [47:16] byte_size, [55:48] mem_props, [87:56] usage_bits
  input  logic [bfbp_pkg::DATA_W-1:0]             s_axis_tdata_i,
  // master side
  output logic                                    m_axis_tvalid_o,
  input  logic                                    m_axis_tready_i,
  // [2:0] status
  output logic [bfbp_pkg::STAT_W-1:0]             m_axis_tuser_o,
  output logic                                    m_axis_tlast_o,
  // [15:0] out_handle, [47:16] out_size, [55:48] out_mem_props, [87:56] out_usage
  output logic [bfbp_pkg::DATA_W-1:0]             m_axis_tdata_o,
  // configuration
  input  logic                                    cfg_we_i,
  input  logic [bfbp_pkg::FACTOR_W-1:0]           cfg_wdata_i
);

  localparam int unsigned CW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned IW = $clog2(POOL_DEPTH);

  // Input unpacking
  bfbp_pkg::req_type_e in_req;
  bfbp_pkg::entry_t    in_entry;

  assign in_req          = bfbp_pkg::req_type_e'(s_axis_tuser_i);
  assign in_entry.handle = s_axis_tdata_i[15:0];
  assign in_entry.size   = s_axis_tdata_i[47:16];
  assign in_entry.flags  = s_axis_tdata_i[55:48];
  assign in_entry.usage  = s_axis_tdata_i[87:56];

  // Registers
  bfbp_pkg::state_e                 state_q, state_d;
  logic [CW-1:0]                    count_q, count_d;
  logic [CW-1:0]                    step_q, step_d;
  logic [bfbp_pkg::FACTOR_W-1:0]    factor_q;
  logic [bfbp_pkg::PROD_W-1:0]      prod_q;
  logic [bfbp_pkg::SIZE_W-1:0]      req_size_q;
  logic [bfbp_pkg::FLAGS_W-1:0]     req_flags_q;
  logic [bfbp_pkg::USAGE_W-1:0]     req_usage_q;
  bfbp_pkg::status_e                pend_status_q, pend_status_d;

  logic                             m_valid_q, m_valid_d;
  bfbp_pkg::status_e                m_status_q, m_status_d;
  logic                             m_last_q, m_last_d;
  bfbp_pkg::entry_t                 m_data_q, m_data_d;

  // Scan results
  logic                             found;
  logic [IW-1:0]                    best_idx;
  bfbp_pkg::entry_t                 best;
  logic                             hit;

  // Control strobes from the output decoder
  logic                             accept;
  logic                             out_free;
  logic                             last_step;
  logic                             full;
  logic                             do_load;
  logic                             do_shift;
  logic                             out_load;
  logic [CW-1:0]                    tail_idx;

  bfbp_pkg::entry_t                 cell_q [POOL_DEPTH];
  bfbp_pkg::cell_ctrl_t             cell_ctrl [POOL_DEPTH];

  assign accept    = s_axis_tvalid_i && s_axis_tready_o;
  assign out_free  = !m_valid_q || m_axis_tready_i;
  assign last_step = (step_q == count_q - CW'(1));
  assign full      = (count_q >= CW'(POOL_DEPTH));
  // reuse only if size <= factor * request, checked at full width
  assign hit       = found && ({{bfbp_pkg::FACTOR_W{1'b0}}, best.size} <= prod_q);

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      bfbp_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (in_req)
            bfbp_pkg::REQ_ALLOC:  state_d = (count_q != '0) ? bfbp_pkg::ST_SCAN
                                                            : bfbp_pkg::ST_DECIDE;
            bfbp_pkg::REQ_RETURN: state_d = bfbp_pkg::ST_PEND;
            bfbp_pkg::REQ_FLUSH:  state_d = (count_q != '0) ? bfbp_pkg::ST_FLUSH
                                                            : bfbp_pkg::ST_PEND;
            default:              state_d = bfbp_pkg::ST_IDLE;
          endcase
        end
      end
      bfbp_pkg::ST_SCAN: begin
        if (last_step) state_d = bfbp_pkg::ST_DECIDE;
      end
      bfbp_pkg::ST_DECIDE: begin
        if (out_free) state_d = hit ? bfbp_pkg::ST_REMOVE : bfbp_pkg::ST_IDLE;
      end
      bfbp_pkg::ST_REMOVE: begin
        if (last_step) state_d = bfbp_pkg::ST_IDLE;
      end
      bfbp_pkg::ST_FLUSH: begin
        if (out_free && last_step) state_d = bfbp_pkg::ST_IDLE;
      end
      bfbp_pkg::ST_PEND: begin
        if (out_free) state_d = bfbp_pkg::ST_IDLE;
      end
      default: state_d = bfbp_pkg::ST_IDLE;
    endcase
  end

  // Outputs of the sequencer
  always_comb begin
    s_axis_tready_o = 1'b0;
    do_load         = 1'b0;
    do_shift        = 1'b0;
    out_load        = 1'b0;
    step_d          = step_q;
    count_d         = count_q;
    pend_status_d   = pend_status_q;
    m_status_d      = m_status_q;
    m_last_d        = m_last_q;
    m_data_d        = m_data_q;
    unique case (state_q)
      bfbp_pkg::ST_IDLE: begin
        s_axis_tready_o = 1'b1;
        step_d          = '0;
        if (accept && in_req == bfbp_pkg::REQ_RETURN) begin
          // append at the tail, or drop when full
          do_load       = !full;
          count_d       = full ? count_q : count_q + CW'(1);
          pend_status_d = full ? bfbp_pkg::STAT_FULL : bfbp_pkg::STAT_STORED;
        end else if (accept && in_req == bfbp_pkg::REQ_FLUSH) begin
          pend_status_d = bfbp_pkg::STAT_EMPTY;
        end
      end
      bfbp_pkg::ST_SCAN: begin
        do_shift = 1'b1;
        step_d   = step_q + CW'(1);
      end
      bfbp_pkg::ST_DECIDE: begin
        step_d = '0;
        if (out_free) begin
          out_load   = 1'b1;
          m_status_d = hit ? bfbp_pkg::STAT_REUSED : bfbp_pkg::STAT_MISS;
          m_data_d   = hit ? best : '0;
          m_last_d   = 1'b1;
        end
      end
      bfbp_pkg::ST_REMOVE: begin
        do_shift = 1'b1;
        step_d   = step_q + CW'(1);
        if (last_step) count_d = count_q - CW'(1);
      end
      bfbp_pkg::ST_FLUSH: begin
        if (out_free) begin
          do_shift   = 1'b1;
          out_load   = 1'b1;
          step_d     = step_q + CW'(1);
          m_status_d = bfbp_pkg::STAT_DESTROY;
          m_data_d   = cell_q[0];
          m_last_d   = last_step;
          if (last_step) count_d = '0;
        end
      end
      bfbp_pkg::ST_PEND: begin
        if (out_free) begin
          out_load   = 1'b1;
          m_status_d = pend_status_q;
          m_data_d   = '0;
          m_last_d   = 1'b1;
        end
      end
      default: begin
        step_d = '0;
      end
    endcase
  end

  assign m_valid_d = out_load ? 1'b1 : (m_axis_tready_i ? 1'b0 : m_valid_q);

  // Tail of the active run: during close-up the run shrinks by one past the dropped entry
  assign tail_idx = (state_q == bfbp_pkg::ST_REMOVE && step_q > CW'(best_idx))
                  ? count_q - CW'(2) : count_q - CW'(1);

  // Per-cell control: load at the fill position, shift with wrap at the run's tail
  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_ctrl
    assign cell_ctrl[i].load      = do_load && (count_q == CW'(i));
    assign cell_ctrl[i].shift     = do_shift;
    assign cell_ctrl[i].wrap_here = (tail_idx == CW'(i)) &&
                                    ((state_q == bfbp_pkg::ST_SCAN) ||
                                     (state_q == bfbp_pkg::ST_REMOVE &&
                                      step_q != CW'(best_idx)));
  end

  // Ring of cells, head at index 0
  for (genvar i = 0; i < POOL_DEPTH; i++) begin : g_cell
    bfbp_cell u_cell (
      .clk_i  (clk_i),
      .ctrl_i (cell_ctrl[i]),
      .load_i (in_entry),
      .head_i (cell_q[0]),
      .next_i (cell_q[(i + 1 < POOL_DEPTH) ? i + 1 : i]),
      .q_o    (cell_q[i])
    );
  end

  bfbp_scan #(
    .IW (IW)
  ) u_scan (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (accept),
    .scan_en_i   (state_q == bfbp_pkg::ST_SCAN),
    .step_i      (step_q[IW-1:0]),
    .head_i      (cell_q[0]),
    .req_size_i  (req_size_q),
    .req_flags_i (req_flags_q),
    .req_usage_i (req_usage_q),
    .found_o     (found),
    .best_idx_o  (best_idx),
    .best_o      (best)
  );

  // Control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= bfbp_pkg::ST_IDLE;
      count_q   <= '0;
      step_q    <= '0;
      factor_q  <= bfbp_pkg::FACTOR_RESET;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      count_q   <= count_d;
      step_q    <= step_d;
      m_valid_q <= m_valid_d;
      if (cfg_we_i) factor_q <= cfg_wdata_i;
    end
  end

  // Payload registers: capture the request and its size limit on accept
  always_ff @(posedge clk_i) begin
    if (accept) begin
      req_size_q  <= in_entry.size;
      req_flags_q <= in_entry.flags;
      req_usage_q <= in_entry.usage;
      prod_q      <= bfbp_pkg::PROD_W'(factor_q) * bfbp_pkg::PROD_W'(in_entry.size);
    end
    pend_status_q <= pend_status_d;
    m_status_q    <= m_status_d;
    m_last_q      <= m_last_d;
    m_data_q      <= m_data_d;
  end

  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tuser_o  = m_status_q;
  assign m_axis_tlast_o  = m_last_q;
  assign m_axis_tdata_o  = {m_data_q.usage, m_data_q.flags, m_data_q.size, m_data_q.handle};

  // The pool never holds more than its depth
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CW'(POOL_DEPTH))
    else $error("entry count beyond pool depth");

  // Close-up and flush passes only run over a non-empty pool
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfbp_pkg::ST_REMOVE || state_q == bfbp_pkg::ST_FLUSH) |-> (count_q != '0))
    else $error("ring pass over an empty pool");

  // The chosen entry lies inside the stored run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == bfbp_pkg::ST_DECIDE && found) |-> (CW'(best_idx) < count_q))
    else $error("best entry index outside the pool");

  // Results without an entry carry an all-zero payload
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && m_status_q != bfbp_pkg::STAT_REUSED &&
     m_status_q != bfbp_pkg::STAT_DESTROY) |-> (m_axis_tdata_o == '0))
    else $error("non-entry result with payload");

endmodule

// File: rtl/core/bfbp_cell.sv
// One pool slot: holds an entry, loads a returned buffer or takes its neighbor's or the head's entry.
module bfbp_cell (
  input  logic                clk_i,
  input  bfbp_pkg::cell_ctrl_t ctrl_i,
  input  bfbp_pkg::entry_t    load_i,
  input  bfbp_pkg::entry_t    head_i,
  input  bfbp_pkg::entry_t    next_i,
  output bfbp_pkg::entry_t    q_o
);

  bfbp_pkg::entry_t entry_q;
  bfbp_pkg::entry_t entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctrl_i.load) begin
      entry_d = load_i;
    end else if (ctrl_i.shift) begin
      // wrap the head around to the tail of the active run
      entry_d = ctrl_i.wrap_here ? head_i : next_i;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign q_o = entry_q;

endmodule

// File: rtl/core/bfbp_scan.sv
// Best-fit tracker: compares the head entry against the request once per scan step.
module bfbp_scan #(
  parameter int unsigned IW = 4
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic                            scan_en_i,
  input  logic [IW-1:0]                   step_i,
  input  bfbp_pkg::entry_t                head_i,
  input  logic [bfbp_pkg::SIZE_W-1:0]     req_size_i,
  input  logic [bfbp_pkg::FLAGS_W-1:0]    req_flags_i,
  input  logic [bfbp_pkg::USAGE_W-1:0]    req_usage_i,
  output logic                            found_o,
  output logic [IW-1:0]                   best_idx_o,
  output bfbp_pkg::entry_t                best_o
);

  logic             found_q, found_d;
  logic [IW-1:0]    best_idx_q, best_idx_d;
  bfbp_pkg::entry_t best_q, best_d;
  logic             fits;
  logic             better;

  assign fits = ((head_i.flags & req_flags_i) == req_flags_i) &&
                ((head_i.usage & req_usage_i) == req_usage_i) &&
                (head_i.size >= req_size_i);
  // strict compare keeps the earliest entry among equal sizes
  assign better = !found_q || (head_i.size < best_q.size);

  always_comb begin
    found_d    = found_q;
    best_idx_d = best_idx_q;
    best_d     = best_q;
    if (start_i) begin
      found_d = 1'b0;
    end else if (scan_en_i && fits && better) begin
      found_d    = 1'b1;
      best_idx_d = step_i;
      best_d     = head_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      found_q <= 1'b0;
    end else begin
      found_q <= found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    best_idx_q <= best_idx_d;
    best_q     <= best_d;
  end

  assign found_o    = found_q;
  assign best_idx_o = best_idx_q;
  assign best_o     = best_q;

  // a new candidate must never be larger than the one it replaces
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (found_q && !start_i && (best_idx_d != best_idx_q)) |-> (best_d.size < best_q.size))
    else $error("best-fit candidate grew");

  // the candidate only moves during a scan
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (!scan_en_i && !start_i) |=> $stable(found_q))
    else $error("best-fit state changed outside a scan");

  // a fitting, better entry seen while scanning is captured with its step index
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (scan_en_i && !start_i && fits && better) |=> (found_q && best_idx_q == $past(step_i)))
    else $error("qualifying entry not captured");

endmodule

// File: dv/bfbp_pool_checker.sv
// Checker for the best-fit buffer pool: tracks pool contents and compares every result.
module bfbp_pool_checker
  import bfbp_pkg::*;
#(
  parameter int unsigned POOL_DEPTH = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_tvalid_i,
  input  logic                s_tready_i,
  input  logic [REQ_W-1:0]    s_tuser_i,
  input  logic [DATA_W-1:0]   s_tdata_i,
  input  logic                m_tvalid_i,
  input  logic                m_tready_i,
  input  logic [STAT_W-1:0]   m_tuser_i,
  input  logic                m_tlast_i,
  input  logic [DATA_W-1:0]   m_tdata_i,
  input  logic                cfg_we_i,
  input  logic [FACTOR_W-1:0] cfg_wdata_i,
  output int                  pending_o,
  output int                  errors_o
);

  localparam int unsigned SIZE_LSB  = HANDLE_W;
  localparam int unsigned FLAGS_LSB = HANDLE_W + SIZE_W;
  localparam int unsigned USAGE_LSB = HANDLE_W + SIZE_W + FLAGS_W;

  typedef struct packed {
    status_e             status;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [FLAGS_W-1:0]  flags;
    logic [USAGE_W-1:0]  usage;
    logic                last;
  } pool_result_t;

  entry_t              shadow_pool_q[$];
  pool_result_t        expected_q[$];
  logic [FACTOR_W-1:0] size_factor;
  pool_result_t        head_r;
  int                  err_count = 0;

  assign errors_o = err_count;

  function automatic pool_result_t result_of(status_e status, entry_t e, logic last);
    pool_result_t r;
    r.status = status;
    r.handle = e.handle;
    r.size   = e.size;
    r.flags  = e.flags;
    r.usage  = e.usage;
    r.last   = last;
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %0h, actual %0h", name, exp_v, act_v);
      err_count++;
    end
  endfunction

  // Work out the results of one request and update the shadow pool
  function automatic void predict_pool_results(req_type_e kind, logic [DATA_W-1:0] payload);
    entry_t            req;
    int                best;
    logic [PROD_W-1:0] ceiling;
    logic [PROD_W-1:0] best_size;
    req.handle = payload[HANDLE_W-1:0];
    req.size   = payload[SIZE_LSB +: SIZE_W];
    req.flags  = payload[FLAGS_LSB +: FLAGS_W];
    req.usage  = payload[USAGE_LSB +: USAGE_W];
    case (kind)
      REQ_ALLOC: begin
        best = -1;
        foreach (shadow_pool_q[i]) begin
          if ((shadow_pool_q[i].flags & req.flags) == req.flags &&
              (shadow_pool_q[i].usage & req.usage) == req.usage &&
              shadow_pool_q[i].size >= req.size &&
              (best < 0 || shadow_pool_q[i].size < shadow_pool_q[best].size))
            best = i;
        end
        // the product is widened before multiplying, so it cannot wrap
        ceiling = PROD_W'(size_factor) * PROD_W'(req.size);
        best_size = (best >= 0) ? PROD_W'(shadow_pool_q[best].size) : '0;
        if (best >= 0 && best_size <= ceiling) begin
          expected_q.push_back(result_of(STAT_REUSED, shadow_pool_q[best], 1'b1));
          shadow_pool_q.delete(best);
        end else begin
          expected_q.push_back(result_of(STAT_MISS, '0, 1'b1));
        end
      end
      REQ_RETURN: begin
        if (shadow_pool_q.size() >= POOL_DEPTH) begin
          expected_q.push_back(result_of(STAT_FULL, '0, 1'b1));
        end else begin
          shadow_pool_q.push_back(req);
          expected_q.push_back(result_of(STAT_STORED, '0, 1'b1));
        end
      end
      REQ_FLUSH: begin
        if (shadow_pool_q.size() == 0) begin
          expected_q.push_back(result_of(STAT_EMPTY, '0, 1'b1));
        end else begin
          foreach (shadow_pool_q[i])
            expected_q.push_back(result_of(STAT_DESTROY, shadow_pool_q[i],
                                           i == shadow_pool_q.size() - 1));
          shadow_pool_q.delete();
        end
      end
      default: ;
    endcase
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      shadow_pool_q.delete();
      expected_q.delete();
      size_factor = FACTOR_RESET;
      pending_o <= 0;
    end else begin
      // results first: a result at this edge belongs to an earlier request
      if (m_tvalid_i && m_tready_i) begin
        if (expected_q.size() == 0) begin
          $error("unexpected result: status %0h handle %0h last %0b",
                 m_tuser_i, m_tdata_i[HANDLE_W-1:0], m_tlast_i);
          err_count++;
        end else begin
          head_r = expected_q.pop_front();
          check_field("status", 32'(head_r.status), 32'(m_tuser_i));
          check_field("out_handle", 32'(head_r.handle), 32'(m_tdata_i[HANDLE_W-1:0]));
          check_field("out_size", head_r.size, m_tdata_i[SIZE_LSB +: SIZE_W]);
          check_field("out_mem_props", 32'(head_r.flags), 32'(m_tdata_i[FLAGS_LSB +: FLAGS_W]));
          check_field("out_usage", head_r.usage, m_tdata_i[USAGE_LSB +: USAGE_W]);
          check_field("last", 32'(head_r.last), 32'(m_tlast_i));
        end
      end
      if (cfg_we_i)
        size_factor = cfg_wdata_i;
      if (s_tvalid_i && s_tready_i)
        predict_pool_results(req_type_e'(s_tuser_i), s_tdata_i);
      pending_o <= expected_q.size();
    end
  end

endmodule

// File: dv/tb_best_fit_buffer_pool.sv
// Testbench top for the best-fit buffer pool: stimulus, idling, watchdog and verdict.
module tb_best_fit_buffer_pool;
  import bfbp_pkg::*;

  localparam int unsigned POOL_DEPTH     = 16;
  // longest legal pass is an allocate over a full pool
  localparam int          DRAIN_CYCLES   = 40;
  localparam int          WATCHDOG_LIMIT = 4000;
  localparam int          ITEMS_PER_PHASE = 12;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                s_tvalid;
  logic                s_tready;
  logic [REQ_W-1:0]    s_tuser;
  logic [DATA_W-1:0]   s_tdata;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [STAT_W-1:0]   m_tuser;
  logic                m_tlast;
  logic [DATA_W-1:0]   m_tdata;
  logic                cfg_we;
  logic [FACTOR_W-1:0] cfg_wdata;

  int results_pending;
  int check_errors;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;
  int stall_cycles   = 0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  best_fit_buffer_pool #(
    .POOL_DEPTH (POOL_DEPTH)
  ) uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tuser_i  (s_tuser),
    .s_axis_tdata_i  (s_tdata),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast),
    .m_axis_tdata_o  (m_tdata),
    .cfg_we_i        (cfg_we),
    .cfg_wdata_i     (cfg_wdata)
  );

  bfbp_pool_checker #(
    .POOL_DEPTH (POOL_DEPTH)
  ) checker_i (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_tvalid_i  (s_tvalid),
    .s_tready_i  (s_tready),
    .s_tuser_i   (s_tuser),
    .s_tdata_i   (s_tdata),
    .m_tvalid_i  (m_tvalid),
    .m_tready_i  (m_tready),
    .m_tuser_i   (m_tuser),
    .m_tlast_i   (m_tlast),
    .m_tdata_i   (m_tdata),
    .cfg_we_i    (cfg_we),
    .cfg_wdata_i (cfg_wdata),
    .pending_o   (results_pending),
    .errors_o    (check_errors)
  );

  // Receiver: stall at the rate of the current phase; zero percent means always ready
  always @(posedge clk_i)
    m_tready <= ($urandom_range(99) >= recv_stall_pct);

  // Watchdog: count cycles in which no transaction moves on any channel
  always @(posedge clk_i) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("tb_best_fit_buffer_pool: done, errors");
    $finish;
  end

  // Present one request and hold it until the block takes it. An optional gap of
  // random length comes first; valid is not lowered when no gap is drawn.
  task automatic push_req(input req_type_e kind, input logic [HANDLE_W-1:0] handle,
                          input logic [SIZE_W-1:0] size, input logic [FLAGS_W-1:0] flags,
                          input logic [USAGE_W-1:0] usage);
    if (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
      s_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < send_idle_pct);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= {usage, flags, size, handle};
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
  endtask

  // Wait until every expected result is in, let a trailing close-up pass or an
  // ignored request finish, then write size_factor
  task automatic write_factor(input logic [FACTOR_W-1:0] value);
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    cfg_we    <= 1'b1;
    cfg_wdata <= value;
    @(posedge clk_i);
    cfg_we    <= 1'b0;
  endtask

  // Sizes: mostly modest, with the extremes and full-range values mixed in
  function automatic logic [SIZE_W-1:0] rand_size();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      2:       return $urandom;
      default: return $urandom_range(4096, 1);
    endcase
  endfunction

  initial begin : stimulus
    req_type_e           kind;
    logic [HANDLE_W-1:0] handle;
    logic [SIZE_W-1:0]   size;
    logic [FLAGS_W-1:0]  flags;
    logic [USAGE_W-1:0]  usage;
    int unsigned         pick;
    int                  counted;

    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tuser   = REQ_NONE;
    s_tdata   = '0;
    cfg_we    = 1'b0;
    cfg_wdata = '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part, size_factor at its reset value of 2
    push_req(REQ_FLUSH, '0, '0, '0, '0);                 // flush of an empty pool
    push_req(REQ_ALLOC, '0, 32'd64, '0, '0);             // allocate from an empty pool
    push_req(REQ_NONE, '1, '1, '1, '1);                  // unused request type: no result
    push_req(REQ_RETURN, '0, '0, '0, '0);                // all-zero buffer
    push_req(REQ_RETURN, '1, '1, '1, '1);                // all-ones buffer
    push_req(REQ_ALLOC, '1, '0, '0, '0);                 // zero size meets the zero entry
    push_req(REQ_ALLOC, '0, 32'd1, '1, '1);              // ratio far too large: miss

    // Largest factor; the ratio test must not wrap at 32 bits
    write_factor(5'd31);
    push_req(REQ_ALLOC, '0, 32'h0800_0000, 8'h80, 32'h8000_0000);   // 31x still short: miss
    push_req(REQ_ALLOC, '0, 32'h0900_0000, 8'h80, 32'h8000_0000);   // product past 2^32: hit

    // Fill the pool with repeating sizes, overflow it, then pick among equal sizes
    for (int i = 0; i < POOL_DEPTH; i++)
      push_req(REQ_RETURN, HANDLE_W'(16'h1000 + i), SIZE_W'(100 + (i % 4) * 50),
               8'h0F | FLAGS_W'($urandom), 32'h1 | $urandom);
    push_req(REQ_RETURN, 16'hBEEF, 32'd100, '1, '1);     // pool full: dropped
    push_req(REQ_ALLOC, '0, 32'd100, 8'h0F, 32'h1);      // earliest of the equal sizes wins
    push_req(REQ_FLUSH, '0, '0, '0, '0);                 // drain everything left

    // Random part: phases of idling and size_factor settings
    for (int p = 0; p < 6; p++) begin
      case (p)
        0:       write_factor(5'd0);
        1:       write_factor(5'd1);
        2:       write_factor(5'd16);
        3:       write_factor(5'd2);
        4:       write_factor(5'd31);
        default: write_factor(5'd7);
      endcase
      case (p % 4)
        0:       begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1:       begin send_idle_pct = 64; recv_stall_pct = 0;  end
        2:       begin send_idle_pct = 0;  recv_stall_pct = 64; end
        default: begin send_idle_pct = 30; recv_stall_pct = 30; end
      endcase
      counted = 0;
      while (counted < ITEMS_PER_PHASE) begin
        pick   = $urandom_range(99);
        handle = HANDLE_W'($urandom);
        size   = rand_size();
        if (pick < 45) begin
          // returned buffers carry many flag and usage bits
          kind  = REQ_RETURN;
          flags = FLAGS_W'($urandom | $urandom);
          usage = $urandom | $urandom;
        end else if (pick < 85) begin
          // requests ask for few bits so that they often find a match
          kind  = REQ_ALLOC;
          flags = FLAGS_W'($urandom & $urandom & $urandom);
          usage = $urandom & $urandom & $urandom;
        end else if (pick < 93) begin
          kind  = REQ_FLUSH;
          flags = FLAGS_W'($urandom);
          usage = $urandom;
        end else begin
          // noise: any request type with unshaped fields
          kind  = req_type_e'($urandom_range(3));
          size  = $urandom;
          flags = FLAGS_W'($urandom);
          usage = $urandom;
        end
        push_req(kind, handle, size, flags, usage);
        if (kind != REQ_NONE)
          counted++;
      end
    end

    // Drop valid, wait out the remaining results and any trailing close-up pass
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (results_pending != 0);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (check_errors == 0 && results_pending == 0)
      $display("tb_best_fit_buffer_pool: done, clean");
    else
      $display("tb_best_fit_buffer_pool: done, errors");
    $finish;
  end

endmodule
